FILE: src/rfia_pkg.sv
// rfia_pkg: types, field widths and codes for the ring fifo with indexed access
// used by rfia_ctrl, rfia_dpath and ring_fifo_indexed_access_top
// no dependencies
package rfia_pkg;

    localparam int KIND_W   = 3;
    localparam int POS_W    = 6;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int CAP_W    = 7;

    localparam int DEPTH_DEF = 64;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    localparam logic [KIND_W-1:0] OP_PUSH  = 3'd0;
    localparam logic [KIND_W-1:0] OP_POP   = 3'd1;
    localparam logic [KIND_W-1:0] OP_PEEK  = 3'd2;
    localparam logic [KIND_W-1:0] OP_READ  = 3'd3;
    localparam logic [KIND_W-1:0] OP_WRITE = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RUNOUT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  position;
        logic [WORD_W-1:0] word_in;
    } t_op;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [WORD_W-1:0]   word_out;
        logic [CAP_W-1:0]    occupancy;
        logic [CAP_W-1:0]    free_space;
    } t_result;

    typedef struct packed {
        logic latch;
        logic access;
    } t_cmd;

endpackage

FILE: src/rfia_ctrl.sv
// rfia_ctrl: operation sequencer, idle -> access -> reply
// depends on rfia_pkg
module rfia_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    output logic          o_done,
    output rfia_pkg::t_cmd o_cmd
);
    import rfia_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_ACCESS = 2'd1;
    localparam logic [1:0] S_REPLY  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_ACCESS;
                end
            end
            S_ACCESS: begin
                n_state = S_REPLY;
            end
            S_REPLY: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy         = (r_state != S_IDLE);
    assign o_done       = (r_state == S_REPLY);
    assign o_cmd.latch  = (r_state == S_IDLE) && start;
    assign o_cmd.access = (r_state == S_ACCESS);

`ifndef SYNTHESIS
    a_accept_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.latch |=> o_cmd.access ##1 o_done)
        else $error("accepted transfer did not reach reply");
    a_done_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("busy held after reply");
    a_one_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.latch, o_cmd.access, o_done}))
        else $error("overlapping controller phases");
`endif

endmodule

FILE: src/rfia_dpath.sv
// rfia_dpath: entry store, head and count registers, capacity register, slot arithmetic
// depends on rfia_pkg
module rfia_dpath #(
    parameter int DEPTH = rfia_pkg::DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rfia_pkg::t_cmd              i_cmd,
    input  rfia_pkg::t_op               i_op,
    input  logic                        i_cfg_we,
    input  logic [rfia_pkg::CAP_W-1:0]  i_cfg_data,
    output rfia_pkg::t_result           o_result
);
    import rfia_pkg::*;

    localparam int AW     = $clog2(DEPTH);
    localparam int SUM_W  = ((AW > CAP_W) ? AW : CAP_W) + 1;
    localparam int CapMax = (DEPTH < 127) ? DEPTH : 127;

    logic [WORD_W-1:0] r_mem [DEPTH];

    logic [CAP_W-1:0]    r_cap;
    logic [AW-1:0]       r_head;
    logic [CAP_W-1:0]    r_count;
    logic [KIND_W-1:0]   r_kind;
    logic [POS_W-1:0]    r_pos;
    logic [WORD_W-1:0]   r_word;
    logic [STATUS_W-1:0] r_status;
    logic [WORD_W-1:0]   r_rd_data;
    logic                r_rd_valid;

    logic [AW-1:0]       n_head;
    logic [CAP_W-1:0]    n_count;
    logic [STATUS_W-1:0] n_status;

    logic [CAP_W-1:0] w_cap;
    logic [CAP_W-1:0] w_offset;
    logic [SUM_W-1:0] w_sum;
    logic [SUM_W-1:0] w_wrap;
    logic [AW-1:0]    w_slot;
    logic             w_in_range;
    logic             w_we;
    logic             w_re;

    // capacity clamped to 1..min(DEPTH, 127)
    always_comb begin
        if (r_cap == '0) begin
            w_cap = CAP_W'(1);
        end else if (r_cap > CAP_W'(CapMax)) begin
            w_cap = CAP_W'(CapMax);
        end else begin
            w_cap = r_cap;
        end
    end

    always_comb begin
        case (r_kind)
            OP_PUSH:  w_offset = r_count;
            OP_POP:   w_offset = CAP_W'(1);
            OP_READ:  w_offset = CAP_W'(r_pos);
            OP_WRITE: w_offset = CAP_W'(r_pos);
            default:  w_offset = '0;
        endcase
    end

    // head plus offset stays below twice the capacity whenever the slot is used
    assign w_sum      = SUM_W'(r_head) + SUM_W'(w_offset);
    assign w_wrap     = (w_sum >= SUM_W'(w_cap)) ? (w_sum - SUM_W'(w_cap)) : w_sum;
    assign w_slot     = w_wrap[AW-1:0];
    assign w_in_range = (CAP_W'(r_pos) < r_count);

    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_status = ST_OK;
        w_we     = 1'b0;
        w_re     = 1'b0;
        case (r_kind)
            OP_PUSH: begin
                if (r_count >= w_cap) begin
                    n_status = ST_RUNOUT;
                end else begin
                    w_we    = 1'b1;
                    n_count = r_count + CAP_W'(1);
                end
            end
            OP_POP: begin
                if (r_count == '0) begin
                    n_status = ST_RUNOUT;
                end else begin
                    n_count = r_count - CAP_W'(1);
                    n_head  = w_slot;
                end
            end
            OP_PEEK: begin
                if (r_count == '0) begin
                    n_status = ST_RUNOUT;
                end else begin
                    w_re = 1'b1;
                end
            end
            OP_READ: begin
                if (!w_in_range) begin
                    n_status = ST_RANGE;
                end else begin
                    w_re = 1'b1;
                end
            end
            OP_WRITE: begin
                if (!w_in_range) begin
                    n_status = ST_RANGE;
                end else begin
                    w_we = 1'b1;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= CAP_RESET;
            r_head  <= '0;
            r_count <= '0;
        end else if (i_cfg_we) begin
            r_cap   <= i_cfg_data;
            r_head  <= '0;
            r_count <= '0;
        end else if (i_cmd.access) begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_kind <= i_op.kind;
            r_pos  <= i_op.position;
            r_word <= i_op.word_in;
        end
        if (i_cmd.access) begin
            r_status   <= n_status;
            r_rd_valid <= w_re;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.access && w_we) begin
            r_mem[w_slot] <= r_word;
        end
        if (i_cmd.access && w_re) begin
            r_rd_data <= r_mem[w_slot];
        end
    end

    assign o_result.status     = r_status;
    assign o_result.word_out   = r_rd_valid ? r_rd_data : '0;
    assign o_result.occupancy  = r_count;
    assign o_result.free_space = w_cap - r_count;

`ifndef SYNTHESIS
    a_count_le_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= w_cap)
        else $error("count above capacity");
    a_head_lt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        SUM_W'(r_head) < SUM_W'(w_cap))
        else $error("head outside capacity");
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.access && !i_cfg_we |=> $stable(r_count) && $stable(r_head))
        else $error("queue state moved without an operation");
    a_failed_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.access && n_status != ST_OK |-> !w_we && !w_re)
        else $error("store access on a failed operation");
`endif

endmodule

FILE: src/ring_fifo_indexed_access_top.sv
// ring_fifo_indexed_access_top: ring fifo with indexed access, top level
// depends on rfia_pkg, rfia_ctrl and rfia_dpath
//
// channel   | transfer when          | payload
// ----------+------------------------+-----------------------------
// operation | start && !busy         | i_op (rfia_pkg::t_op)
// result    | o_done                 | o_result (rfia_pkg::t_result)
// config    | i_cfg_we               | i_cfg_data (capacity)
//
// each operation passes through accept, store access and result, in that order
// o_done rises when the controller moves from store access to reply and holds for one cycle; busy covers both
// the controller sets the pace: busy holds through the store access and the reply
// synchronous active-low reset empties the queue and sets capacity to 64
// a capacity write also empties the queue; results cannot be held off
module ring_fifo_indexed_access_top #(
    parameter int DEPTH = rfia_pkg::DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  rfia_pkg::t_op               i_op,
    output logic                        o_done,
    output rfia_pkg::t_result           o_result,
    input  logic                        i_cfg_we,
    input  logic [rfia_pkg::CAP_W-1:0]  i_cfg_data
);
    import rfia_pkg::*;

    t_cmd w_cmd;

    rfia_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .o_cmd   (w_cmd)
    );

    rfia_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_op       (i_op),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_result   (o_result)
    );

endmodule
